// ----- rtl/mft_pkg.sv -----
package mft_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int MOTOR_W    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    localparam logic [10:0] ID_BASE = 11'h200;
    localparam logic [10:0] ID_LO   = ID_BASE + 11'd1;
    localparam logic [10:0] ID_HI   = ID_BASE + 11'(NUM_MOTORS);
    localparam logic [7:0]  AGE_MAX = 8'd255;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSES_PER_ROUND    = 3'd0,
        REG_MOTOR_ENABLE        = 3'd1,
        REG_STALL_DISABLES      = 3'd2,
        REG_STALL_STEP_LIMIT    = 3'd3,
        REG_STALL_CURRENT_LIMIT = 3'd4,
        REG_STALL_TICKS         = 3'd5,
        REG_RX_AGE_LIMIT        = 3'd6,
        REG_TIMEOUT_TICKS       = 3'd7
    } cfg_idx_t;

    // settings the watchdog checks need
    typedef struct packed {
        logic        stall_disables;
        logic [14:0] stall_step_limit;
        logic [14:0] stall_current_limit;
        logic [9:0]  stall_ticks;
        logic [7:0]  rx_age_limit;
        logic [4:0]  timeout_ticks;
    } wd_cfg_t;

    // per motor watchdog state
    typedef struct packed {
        logic [9:0] stall_count;
        logic [4:0] loss_count;
        logic [7:0] rx_age;
        logic       stall_flag;
        logic       timeout_flag;
        logic       disable_request;
    } wd_state_t;

    localparam logic [15:0] RST_PULSES_PER_ROUND = 16'd8191;
    localparam wd_cfg_t RST_WD_CFG = '{
        stall_disables:      1'b0,
        stall_step_limit:    15'd5,
        stall_current_limit: 15'd3000,
        stall_ticks:         10'd500,
        rx_age_limit:        8'd50,
        timeout_ticks:       5'd20
    };

endpackage

// ----- rtl/mft_watchdog.sv -----
module mft_watchdog
    import mft_pkg::*;
(
    input  wd_cfg_t     cfg,
    input  logic [15:0] last_step,
    input  logic [15:0] last_current,
    input  wd_state_t   cur,
    output wd_state_t   nxt
);

    logic signed [16:0] step_s;
    logic        [16:0] step_mag;
    logic signed [16:0] curr_s;
    logic               standstill;
    logic        [10:0] stall_inc;
    logic        [7:0]  age_inc;
    logic        [5:0]  loss_inc;

    always_comb
    begin
        step_s     = {last_step[15], last_step};
        step_mag   = step_s[16] ? 17'(-step_s) : 17'(step_s);
        curr_s     = {last_current[15], last_current};
        standstill = (step_mag < {2'b00, cfg.stall_step_limit}) &&
                     (curr_s > $signed({2'b00, cfg.stall_current_limit}));
        stall_inc  = {1'b0, cur.stall_count} + 11'd1;
        age_inc    = (cur.rx_age < AGE_MAX) ? cur.rx_age + 8'd1 : cur.rx_age;
        loss_inc   = {1'b0, cur.loss_count} + 6'd1;

        nxt        = cur;
        nxt.rx_age = age_inc;

        if (standstill)
        begin
            if (stall_inc > {1'b0, cfg.stall_ticks})
            begin
                nxt.stall_count = '0;
                nxt.stall_flag  = 1'b1;
                if (cfg.stall_disables)
                    nxt.disable_request = 1'b1;
            end
            else
            begin
                nxt.stall_count = stall_inc[9:0];
            end
        end
        else
        begin
            nxt.stall_count = '0;
        end

        // age compare uses the freshly advanced age
        if (age_inc > cfg.rx_age_limit)
        begin
            if (loss_inc > {1'b0, cfg.timeout_ticks})
            begin
                nxt.loss_count      = '0;
                nxt.timeout_flag    = 1'b1;
                nxt.disable_request = 1'b1;
            end
            else
            begin
                nxt.loss_count = loss_inc[4:0];
            end
        end
        else
        begin
            nxt.loss_count = '0;
        end
    end

endmodule

// ----- rtl/motor_feedback_tracker_top.sv -----
// Motor feedback tracker: multi-turn encoder unwrap and stall / link-loss
// watchdog for NUM_MOTORS motors.
// Input stream (s_axis): one transaction is either a feedback frame
// (tuser func = 0) or a control tick (tuser func = 1). A standard data frame
// with id 0x201 to 0x204 updates that motor's step, multi-turn total, current
// and receive age; a tick runs the watchdog on every enabled motor.
// Output stream (m_axis): exactly one result transaction per input
// transaction, in order. It carries the frame's motor, unwrapped step and
// total (zero when no frame was taken) plus the sticky stall, timeout and
// disable masks after the update.
// The input register loads at the accept edge and the result register when
// the output is free. Throughput: one transaction per cycle while the receiver
// does not stall; the update is a single pass of adds and compares between
// the two registers.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction before s_axis_tready drops.
// Reset clears all motor state, marks every motor's first frame to zero its
// total, and loads the default configuration. Configuration writes on cfg_we
// take effect at once and belong between transactions, with the block idle.
module motor_feedback_tracker_top
    import mft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_id[10:0], pulse_raw[26:11], current_meas[42:27], zero fill
    input  logic [47:0]           s_axis_tdata,
    // func[0], frame_ok[1]
    input  logic [1:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // motor_index[1:0], pulse_step[17:2], position_total[49:18],
    // stall_mask[53:50], timeout_mask[57:54], disable_mask[61:58], zero fill
    output logic [63:0]           m_axis_tdata,
    // accepted[0]
    output logic [0:0]            m_axis_tuser
);

    // configuration
    logic [15:0]           ppr_reg;
    logic [NUM_MOTORS-1:0] motor_enable_reg;
    wd_cfg_t               wd_cfg_reg;

    // input register
    logic        in_valid_reg;
    logic        func_reg;
    logic        frame_ok_reg;
    logic [10:0] frame_id_reg;
    logic [15:0] pulse_raw_reg;
    logic [15:0] current_reg;

    // result register
    logic        out_valid_reg;
    logic        acc_reg;
    logic [1:0]  idx_reg;
    logic [15:0] step_reg;
    logic [31:0] total_reg;
    logic [3:0]  stall_mask_reg;
    logic [3:0]  timeout_mask_reg;
    logic [3:0]  disable_mask_reg;

    // motor state
    logic [15:0] prev_reading_reg [NUM_MOTORS];
    logic [31:0] pulse_total_reg  [NUM_MOTORS];
    logic [15:0] last_step_reg    [NUM_MOTORS];
    logic [15:0] last_current_reg [NUM_MOTORS];
    logic        zero_pending_reg [NUM_MOTORS];
    wd_state_t   wd_reg           [NUM_MOTORS];

    logic [15:0] prev_reading_next [NUM_MOTORS];
    logic [31:0] pulse_total_next  [NUM_MOTORS];
    logic [15:0] last_step_next    [NUM_MOTORS];
    logic [15:0] last_current_next [NUM_MOTORS];
    logic        zero_pending_next [NUM_MOTORS];
    wd_state_t   wd_next           [NUM_MOTORS];
    wd_state_t   wd_tick           [NUM_MOTORS];

    logic               out_free;
    logic               adv;
    logic               hit;
    logic [10:0]        id_off;
    logic [MOTOR_W-1:0] m_sel;
    logic [15:0]        diff;
    logic signed [16:0] diff_s;
    logic [16:0]        diff_mag;
    logic [15:0]        span16;
    logic [15:0]        step;
    logic [31:0]        total_new;
    logic [3:0]         stall_mask_next;
    logic [3:0]         timeout_mask_next;
    logic [3:0]         disable_mask_next;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    genvar g;
    generate
        for (g = 0; g < NUM_MOTORS; g++)
        begin : g_wd
            mft_watchdog u_wd (
                .cfg          (wd_cfg_reg),
                .last_step    (last_step_reg[g]),
                .last_current (last_current_reg[g]),
                .cur          (wd_reg[g]),
                .nxt          (wd_tick[g])
            );
        end
    endgenerate

    // frame path
    always_comb
    begin
        id_off    = frame_id_reg - ID_LO;
        m_sel     = id_off[MOTOR_W-1:0];
        hit       = !func_reg && frame_ok_reg &&
                    (frame_id_reg >= ID_LO) && (frame_id_reg <= ID_HI);
        diff      = pulse_raw_reg - prev_reading_reg[m_sel];
        diff_s    = {diff[15], diff};
        diff_mag  = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);
        span16    = ppr_reg + 16'd1;
        // unwrap by one turn when the step exceeds half a turn
        if (diff_mag > {2'b00, ppr_reg[15:1]})
            step = diff[15] ? diff + span16 : diff - span16;
        else
            step = diff;
        total_new = zero_pending_reg[m_sel] ? 32'd0 :
                    pulse_total_reg[m_sel] + {{16{step[15]}}, step};
    end

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            prev_reading_next[i] = prev_reading_reg[i];
            pulse_total_next[i]  = pulse_total_reg[i];
            last_step_next[i]    = last_step_reg[i];
            last_current_next[i] = last_current_reg[i];
            zero_pending_next[i] = zero_pending_reg[i];
            wd_next[i]           = wd_reg[i];
            if (func_reg)
            begin
                if (motor_enable_reg[i])
                    wd_next[i] = wd_tick[i];
            end
            else if (hit && (m_sel == MOTOR_W'(i)))
            begin
                prev_reading_next[i] = pulse_raw_reg;
                pulse_total_next[i]  = total_new;
                last_step_next[i]    = step;
                last_current_next[i] = current_reg;
                zero_pending_next[i] = 1'b0;
                wd_next[i].rx_age    = '0;
            end
        end

        stall_mask_next   = '0;
        timeout_mask_next = '0;
        disable_mask_next = '0;
        for (int i = 0; i < NUM_MOTORS && i < 4; i++)
        begin
            stall_mask_next[i]   = wd_next[i].stall_flag;
            timeout_mask_next[i] = wd_next[i].timeout_flag;
            disable_mask_next[i] = wd_next[i].disable_request;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg          <= RST_PULSES_PER_ROUND;
            motor_enable_reg <= '0;
            wd_cfg_reg       <= RST_WD_CFG;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_PULSES_PER_ROUND:    ppr_reg <= cfg_data;
                REG_MOTOR_ENABLE:        motor_enable_reg <= cfg_data[NUM_MOTORS-1:0];
                REG_STALL_DISABLES:      wd_cfg_reg.stall_disables <= cfg_data[0];
                REG_STALL_STEP_LIMIT:    wd_cfg_reg.stall_step_limit <= cfg_data[14:0];
                REG_STALL_CURRENT_LIMIT: wd_cfg_reg.stall_current_limit <= cfg_data[14:0];
                REG_STALL_TICKS:         wd_cfg_reg.stall_ticks <= cfg_data[9:0];
                REG_RX_AGE_LIMIT:        wd_cfg_reg.rx_age_limit <= cfg_data[7:0];
                REG_TIMEOUT_TICKS:       wd_cfg_reg.timeout_ticks <= cfg_data[4:0];
                default:                 ppr_reg <= ppr_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            func_reg      <= s_axis_tuser[0];
            frame_ok_reg  <= s_axis_tuser[1];
            frame_id_reg  <= s_axis_tdata[10:0];
            pulse_raw_reg <= s_axis_tdata[26:11];
            current_reg   <= s_axis_tdata[42:27];
        end
    end

    // motor state and result register advance together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                prev_reading_reg[i] <= '0;
                pulse_total_reg[i]  <= '0;
                last_step_reg[i]    <= '0;
                last_current_reg[i] <= '0;
                zero_pending_reg[i] <= 1'b1;
                wd_reg[i]           <= '0;
            end
        end
        else
        begin
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (adv)
            begin
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    prev_reading_reg[i] <= prev_reading_next[i];
                    pulse_total_reg[i]  <= pulse_total_next[i];
                    last_step_reg[i]    <= last_step_next[i];
                    last_current_reg[i] <= last_current_next[i];
                    zero_pending_reg[i] <= zero_pending_next[i];
                    wd_reg[i]           <= wd_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg          <= hit;
            idx_reg          <= hit ? 2'(m_sel) : 2'd0;
            step_reg         <= hit ? step : 16'd0;
            total_reg        <= hit ? total_new : 32'd0;
            stall_mask_reg   <= stall_mask_next;
            timeout_mask_reg <= timeout_mask_next;
            disable_mask_reg <= disable_mask_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = acc_reg;
    assign m_axis_tdata  = {2'b00, disable_mask_reg, timeout_mask_reg, stall_mask_reg,
                            total_reg, step_reg, idx_reg};

endmodule
